// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSTP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DSTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/dstp_pkg.sv =====
// Types, command codes and the day name table of the schedule token parser.
package dstp_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       token_end;
        logic       list_end;
    } in_t;

    typedef struct packed {
        logic        status;
        logic [2:0]  day_code;
        logic [13:0] start_value;
        logic [13:0] end_value;
        logic        last_of_group;
    } out_t;

    // Command kinds passed from the front to the back.
    localparam logic [1:0] CMD_ERR   = 2'd0;
    localparam logic [1:0] CMD_LIST  = 2'd1;
    localparam logic [1:0] CMD_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  lo;
        logic [2:0]  hi;
        logic [13:0] start_value;
        logic [13:0] end_value;
    } cmd_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } day_match_t;

    localparam int NUM_DAYS = 7;

    localparam logic [23:0] DAY_NAMES [NUM_DAYS] = '{
        24'h4D4F4E, // MON
        24'h545545, // TUE
        24'h574544, // WED
        24'h544855, // THU
        24'h465249, // FRI
        24'h53554E, // SUN
        24'h534154  // SAT
    };

    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [3:0] NAME_LEN  = 4'd3;
    localparam logic [3:0] DIGIT_LEN = 4'd4;
    localparam logic [3:0] TIME_LEN  = 4'd9;
    localparam logic [3:0] CNT_SAT   = 4'd15;

    function automatic day_match_t day_lookup(input logic [23:0] name);
        day_match_t m;
        m.hit  = 1'b0;
        m.code = 3'd0;
        for (int i = 0; i < NUM_DAYS; i++) begin
            if (!m.hit && name == DAY_NAMES[i]) begin
                m.hit  = 1'b1;
                m.code = 3'(i);
            end
        end
        return m;
    endfunction

endpackage

// ===== design/dstp_front.sv =====
// Front end: gathers characters into tokens, classifies them and runs the group grammar.
module dstp_front #(
    parameter int LIST_MAX = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_accept,
    input  dstp_pkg::in_t               in_data,
    output logic                        push,
    output dstp_pkg::cmd_t              push_cmd,
    output logic [$clog2(LIST_MAX+1)-1:0] push_count,
    output logic [LIST_MAX*3-1:0]       push_days
);
    localparam int CW = $clog2(LIST_MAX + 1);
    localparam int IW = $clog2(LIST_MAX);
    localparam logic [CW-1:0] LIST_FULL = CW'(LIST_MAX);

    localparam logic [2:0] GS_FIRST      = 3'd0;
    localparam logic [2:0] GS_ONE_DAY    = 3'd1;
    localparam logic [2:0] GS_AFTER_DASH = 3'd2;
    localparam logic [2:0] GS_NEED_TIME  = 3'd3;
    localparam logic [2:0] GS_IN_LIST    = 3'd4;

    localparam logic [1:0] TK_DAY  = 2'd0;
    localparam logic [1:0] TK_DASH = 2'd1;
    localparam logic [1:0] TK_TIME = 2'd2;
    localparam logic [1:0] TK_BAD  = 2'd3;

    logic [3:0]    cnt_reg, cnt_next;
    logic [23:0]   name_reg, name_next;
    logic          dok_reg, dok_next;
    logic [13:0]   fv_reg, fv_next;
    logic [13:0]   sv_reg, sv_next;
    logic [2:0]    gs_reg, gs_next;
    logic [CW-1:0] dcnt_reg, dcnt_next;
    logic          err_reg, err_next;
    logic [2:0]    days_reg [LIST_MAX];

    // absorbed token values, before the token-end decision
    logic [3:0]    cnt_a;
    logic [23:0]   name_a;
    logic          dok_a;
    logic [13:0]   fv_a, sv_a;
    logic          is_digit;
    logic [3:0]    digit;
    logic [13:0]   fv_acc, sv_acc;

    dstp_pkg::day_match_t dm;
    logic [1:0]    tk;

    logic [2:0]    gs_g;
    logic [CW-1:0] dcnt_g;
    logic          err_g;
    logic          do_err, do_list, do_range;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic          te, le;

    assign te = in_data.token_end;
    assign le = in_data.list_end;

    always_comb begin
        is_digit = (in_data.ch >= dstp_pkg::CH_ZERO) && (in_data.ch <= dstp_pkg::CH_NINE);
        digit    = 4'(in_data.ch - dstp_pkg::CH_ZERO);
        fv_acc   = 14'(fv_reg << 3) + 14'(fv_reg << 1) + 14'(digit);
        sv_acc   = 14'(sv_reg << 3) + 14'(sv_reg << 1) + 14'(digit);
        dok_a    = dok_reg;
        fv_a     = fv_reg;
        sv_a     = sv_reg;
        if (cnt_reg < dstp_pkg::DIGIT_LEN) begin
            if (is_digit && dok_reg) fv_a = fv_acc;
            else dok_a = 1'b0;
        end else if (cnt_reg == dstp_pkg::DIGIT_LEN) begin
            if (in_data.ch != dstp_pkg::CH_DASH) dok_a = 1'b0;
        end else if (cnt_reg < dstp_pkg::TIME_LEN) begin
            if (is_digit && dok_reg) sv_a = sv_acc;
            else dok_a = 1'b0;
        end else begin
            dok_a = 1'b0;
        end
        name_a = {name_reg[15:0], in_data.ch};
        cnt_a  = (cnt_reg == dstp_pkg::CNT_SAT) ? cnt_reg : cnt_reg + 4'd1;
    end

    // token class
    always_comb begin
        dm = dstp_pkg::day_lookup(name_a);
        if (cnt_a == dstp_pkg::NAME_LEN) begin
            tk = dm.hit ? TK_DAY : TK_BAD;
        end else if (cnt_a == 4'd1 && name_a == {16'h0000, dstp_pkg::CH_DASH}) begin
            tk = TK_DASH;
        end else if (cnt_a == dstp_pkg::TIME_LEN && dok_a) begin
            tk = TK_TIME;
        end else begin
            tk = TK_BAD;
        end
    end

    // group grammar on a finished token
    always_comb begin
        gs_g     = gs_reg;
        dcnt_g   = dcnt_reg;
        err_g    = err_reg;
        do_err   = 1'b0;
        do_list  = 1'b0;
        do_range = 1'b0;
        wr_en    = 1'b0;
        wr_idx   = '0;
        if (!err_reg) begin
            if (tk == TK_BAD) begin
                do_err = 1'b1;
            end else begin
                case (gs_reg)
                    GS_FIRST: begin
                        if (tk == TK_DAY) begin
                            wr_en  = 1'b1;
                            wr_idx = '0;
                            dcnt_g = CW'(1);
                            gs_g   = GS_ONE_DAY;
                        end else begin
                            do_err = 1'b1;
                        end
                    end
                    GS_ONE_DAY, GS_IN_LIST: begin
                        if (tk == TK_DAY) begin
                            if (dcnt_reg >= LIST_FULL) begin
                                do_err = 1'b1;
                            end else begin
                                wr_en  = 1'b1;
                                wr_idx = dcnt_reg[IW-1:0];
                                dcnt_g = dcnt_reg + CW'(1);
                                gs_g   = GS_IN_LIST;
                            end
                        end else if (tk == TK_DASH && gs_reg == GS_ONE_DAY) begin
                            gs_g = GS_AFTER_DASH;
                        end else if (tk == TK_TIME) begin
                            do_list = 1'b1;
                            gs_g    = GS_FIRST;
                            dcnt_g  = '0;
                        end else begin
                            do_err = 1'b1;
                        end
                    end
                    GS_AFTER_DASH: begin
                        if (tk == TK_DAY) begin
                            wr_en  = 1'b1;
                            wr_idx = IW'(1);
                            dcnt_g = CW'(2);
                            gs_g   = GS_NEED_TIME;
                        end else begin
                            do_err = 1'b1;
                        end
                    end
                    GS_NEED_TIME: begin
                        if (tk == TK_TIME) begin
                            // empty range when start day is after end day
                            do_range = (days_reg[0] <= days_reg[1]);
                            gs_g     = GS_FIRST;
                            dcnt_g   = '0;
                        end else begin
                            do_err = 1'b1;
                        end
                    end
                    default: begin
                        do_err = 1'b1;
                    end
                endcase
            end
            if (do_err) begin
                err_g  = 1'b1;
                gs_g   = GS_FIRST;
                dcnt_g = '0;
                wr_en  = 1'b0;
            end
        end
        // list end: an open group is an error, then start clean
        if (le) begin
            if (!err_g && gs_g != GS_FIRST) do_err = 1'b1;
            gs_g   = GS_FIRST;
            dcnt_g = '0;
            err_g  = 1'b0;
        end
    end

    always_comb begin
        cnt_next  = cnt_reg;
        name_next = name_reg;
        dok_next  = dok_reg;
        fv_next   = fv_reg;
        sv_next   = sv_reg;
        gs_next   = gs_reg;
        dcnt_next = dcnt_reg;
        err_next  = err_reg;
        if (in_accept) begin
            if (te) begin
                cnt_next  = '0;
                name_next = '0;
                dok_next  = 1'b1;
                fv_next   = '0;
                sv_next   = '0;
                gs_next   = gs_g;
                dcnt_next = dcnt_g;
                err_next  = err_g;
            end else begin
                cnt_next  = cnt_a;
                name_next = name_a;
                dok_next  = dok_a;
                fv_next   = fv_a;
                sv_next   = sv_a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            name_reg <= '0;
            dok_reg  <= 1'b1;
            fv_reg   <= '0;
            sv_reg   <= '0;
            gs_reg   <= GS_FIRST;
            dcnt_reg <= '0;
            err_reg  <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            name_reg <= name_next;
            dok_reg  <= dok_next;
            fv_reg   <= fv_next;
            sv_reg   <= sv_next;
            gs_reg   <= gs_next;
            dcnt_reg <= dcnt_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && te && wr_en) begin
            days_reg[wr_idx] <= dm.code;
        end
    end

    always_comb begin
        for (int i = 0; i < LIST_MAX; i++) begin
            push_days[i*3 +: 3] = days_reg[i];
        end
    end

    assign push       = in_accept && te && (do_err || do_list || do_range);
    assign push_count = dcnt_reg;

    always_comb begin
        push_cmd.kind        = do_err ? dstp_pkg::CMD_ERR :
                               (do_list ? dstp_pkg::CMD_LIST : dstp_pkg::CMD_RANGE);
        push_cmd.lo          = days_reg[0];
        push_cmd.hi          = days_reg[1];
        push_cmd.start_value = fv_a;
        push_cmd.end_value   = sv_a;
    end

endmodule

// ===== design/dstp_cmd_fifo.sv =====
// Two-entry command queue between the front end and the result sequencer.
module dstp_cmd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wr_data;
    end

endmodule

// ===== design/dstp_back.sv =====
// Result sequencer: expands one queued command into its result transfers.
module dstp_back #(
    parameter int LIST_MAX = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  dstp_pkg::cmd_t                q_cmd,
    input  logic [$clog2(LIST_MAX+1)-1:0] q_count,
    input  logic [LIST_MAX*3-1:0]         q_days,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dstp_pkg::out_t                m_data
);
    localparam int CW = $clog2(LIST_MAX + 1);
    localparam int IW = $clog2(LIST_MAX);

    logic           act_reg;
    logic [1:0]     kind_reg;
    logic [2:0]     cur_reg;
    logic [2:0]     hi_reg;
    logic [13:0]    sv_reg, ev_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  pos_reg;
    logic [2:0]     days_reg [LIST_MAX];
    logic           mv_reg;
    dstp_pkg::out_t md_reg;

    logic           out_free;
    logic           emit;
    logic           last;
    dstp_pkg::out_t res;

    assign out_free = !mv_reg || m_ready;
    assign q_pop    = !act_reg && q_valid;
    assign emit     = act_reg && out_free;
    assign m_valid  = mv_reg;
    assign m_data   = md_reg;

    always_comb begin
        res.status      = 1'b0;
        res.day_code    = 3'd0;
        res.start_value = sv_reg;
        res.end_value   = ev_reg;
        last            = 1'b1;
        case (kind_reg)
            dstp_pkg::CMD_LIST: begin
                res.day_code = days_reg[pos_reg[IW-1:0]];
                last         = (pos_reg + CW'(1) == cnt_reg);
            end
            dstp_pkg::CMD_RANGE: begin
                res.day_code = cur_reg;
                last         = (cur_reg == hi_reg);
            end
            default: begin
                res.status      = 1'b1;
                res.start_value = '0;
                res.end_value   = '0;
            end
        endcase
        res.last_of_group = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
            mv_reg  <= 1'b0;
        end else begin
            if (q_pop) begin
                act_reg <= 1'b1;
            end else if (emit && last) begin
                act_reg <= 1'b0;
            end
            if (emit) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg <= q_cmd.kind;
            cur_reg  <= q_cmd.lo;
            hi_reg   <= q_cmd.hi;
            sv_reg   <= q_cmd.start_value;
            ev_reg   <= q_cmd.end_value;
            cnt_reg  <= q_count;
            pos_reg  <= '0;
            for (int i = 0; i < LIST_MAX; i++) begin
                days_reg[i] <= q_days[i*3 +: 3];
            end
        end else if (emit) begin
            pos_reg <= pos_reg + CW'(1);
            cur_reg <= cur_reg + 3'd1;
        end
        if (emit) begin
            md_reg <= res;
        end
    end

endmodule

// ===== design/day_schedule_token_parser.sv =====
// Top level of the day schedule token parser: front end, command queue, result sequencer.
//
// Characters of a schedule text arrive on the s_ channel, one per transfer, with
// token_end marking the last character of a token and list_end the last token of the
// list. The front end takes one character every cycle while s_ready is high: it builds
// the token, classifies it (day name, dash, DDDD-DDDD time range or invalid) and steps
// the group grammar in the same cycle. When a group closes with its time range (unless
// its dash range is empty), or on a malformed list, it posts one command into a
// two-entry queue. The back end loads a command and turns it into result transfers on
// the m_ channel, one per cycle while m_ready is high: one per listed day (up to
// LIST_MAX) or one per code of an inclusive dash range, each carrying the start and end
// times and a last_of_group flag; an error is a single result with status 1 and
// last_of_group set. The front end stalls (s_ready low) only while both queue entries
// are taken. After an error the parser drops tokens until a token with list_end.
module day_schedule_token_parser #(
    parameter int LIST_MAX = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dstp_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output dstp_pkg::out_t m_data
);
`include "assert_macros.svh"

    localparam int CW = $clog2(LIST_MAX + 1);
    localparam int DW = LIST_MAX * 3;
    localparam int HW = $bits(dstp_pkg::cmd_t);
    localparam int QW = HW + CW + DW;

    logic           in_accept;
    logic           push;
    dstp_pkg::cmd_t push_cmd;
    logic [CW-1:0]  push_count;
    logic [DW-1:0]  push_days;
    logic [QW-1:0]  q_rd;
    logic           q_full, q_empty, q_pop;

    // a character transfer is taken whenever the queue has room for its command
    assign s_ready   = !q_full;
    assign in_accept = s_valid && s_ready;

    dstp_front #(
        .LIST_MAX(LIST_MAX)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_data   (s_data),
        .push      (push),
        .push_cmd  (push_cmd),
        .push_count(push_count),
        .push_days (push_days)
    );

    dstp_cmd_fifo #(
        .WIDTH(QW)
    ) u_fifo (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .wr_data({push_cmd, push_count, push_days}),
        .pop    (q_pop),
        .rd_data(q_rd),
        .full   (q_full),
        .empty  (q_empty)
    );

    dstp_back #(
        .LIST_MAX(LIST_MAX)
    ) u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_valid(!q_empty),
        .q_cmd  (dstp_pkg::cmd_t'(q_rd[QW-1 -: HW])),
        .q_count(q_rd[DW +: CW]),
        .q_days (q_rd[DW-1:0]),
        .q_pop  (q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // error results always close their group
    `DSTP_ASSERT_IMP(a_err_is_last, aclk, aresetn, m_valid && m_data.status, m_data.last_of_group)
    // day entries only carry real day codes
    `DSTP_ASSERT_IMP(a_day_code_ok, aclk, aresetn, m_valid && !m_data.status, m_data.day_code <= 3'd6)
    // the sequencer never loads from an empty queue
    `DSTP_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, q_pop, !q_empty)

endmodule

// ===== dv/day_schedule_result_checker.sv =====
// Checker for the schedule token parser: grammar predictor and result comparison.
module day_schedule_result_checker #(
    parameter int LIST_MAX = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  dstp_pkg::in_t  s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  dstp_pkg::out_t m_data,
    output int             fail_count,
    output int             pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        G_FIRST_DAY, G_ONE_DAY, G_AFTER_DASH, G_NEED_TIME, G_IN_LIST
    } grammar_t;

    typedef enum logic [1:0] {TOK_DAY, TOK_DASH, TOK_TIME, TOK_BAD} token_kind_t;

    // token being gathered
    logic [3:0]  n_chars;
    logic [23:0] last3;
    logic        digits_good;
    int unsigned lead_val;
    int unsigned trail_val;

    // group being gathered
    grammar_t    phase;
    logic [2:0]  days [LIST_MAX];
    int          n_days;
    logic        dropping;

    dstp_pkg::out_t expected_days[$];

    function automatic dstp_pkg::out_t day_entry(input logic [2:0] code, input int unsigned sv,
                                                 input int unsigned ev, input logic last);
        dstp_pkg::out_t r;
        r.status        = 1'b0;
        r.day_code      = code;
        r.start_value   = 14'(sv);
        r.end_value     = 14'(ev);
        r.last_of_group = last;
        return r;
    endfunction

    task automatic expect_result(input dstp_pkg::out_t r);
        expected_days = {expected_days, r};
    endtask

    task automatic start_token();
        n_chars     = '0;
        last3       = '0;
        digits_good = 1'b1;
        lead_val    = 0;
        trail_val   = 0;
    endtask

    task automatic push_error();
        dstp_pkg::out_t r;
        r               = '0;
        r.status        = 1'b1;
        r.last_of_group = 1'b1;
        expect_result(r);
        dropping = 1'b1;
        phase    = G_FIRST_DAY;
        n_days   = 0;
    endtask

    task automatic take_char(input dstp_pkg::in_t it);
        token_kind_t kind;
        logic [2:0]  code;
        logic        is_digit;
        int unsigned sv;
        int unsigned ev;

        // absorb one character: DDDD-DDDD digits plus a three-char name window
        is_digit = (it.ch >= dstp_pkg::CH_ZERO) && (it.ch <= dstp_pkg::CH_NINE);
        if (n_chars < dstp_pkg::DIGIT_LEN) begin
            if (is_digit && digits_good) lead_val = lead_val * 10 + (it.ch - dstp_pkg::CH_ZERO);
            else digits_good = 1'b0;
        end else if (n_chars == dstp_pkg::DIGIT_LEN) begin
            if (it.ch != dstp_pkg::CH_DASH) digits_good = 1'b0;
        end else if (n_chars < dstp_pkg::TIME_LEN) begin
            if (is_digit && digits_good)
                trail_val = trail_val * 10 + (it.ch - dstp_pkg::CH_ZERO);
            else digits_good = 1'b0;
        end else begin
            digits_good = 1'b0;
        end
        last3 = {last3[15:0], it.ch};
        if (n_chars < dstp_pkg::CNT_SAT) n_chars++;

        if (!it.token_end) return;

        kind = TOK_BAD;
        code = '0;
        if (n_chars == dstp_pkg::NAME_LEN) begin
            for (int i = 0; i < dstp_pkg::NUM_DAYS; i++) begin
                if (kind == TOK_BAD && last3 == dstp_pkg::DAY_NAMES[i]) begin
                    kind = TOK_DAY;
                    code = 3'(i);
                end
            end
        end else if (n_chars == 4'd1 && last3 == {16'h0, dstp_pkg::CH_DASH}) begin
            kind = TOK_DASH;
        end else if (n_chars == dstp_pkg::TIME_LEN && digits_good) begin
            kind = TOK_TIME;
        end
        sv = lead_val;
        ev = trail_val;
        start_token();

        if (!dropping) begin
            if (kind == TOK_BAD) begin
                push_error();
            end else begin
                case (phase)
                    G_FIRST_DAY: begin
                        if (kind == TOK_DAY) begin
                            days[0] = code;
                            n_days  = 1;
                            phase   = G_ONE_DAY;
                        end else begin
                            push_error();
                        end
                    end
                    G_ONE_DAY, G_IN_LIST: begin
                        if (kind == TOK_DAY) begin
                            if (n_days >= LIST_MAX) begin
                                push_error();
                            end else begin
                                days[n_days] = code;
                                n_days++;
                                phase = G_IN_LIST;
                            end
                        end else if (kind == TOK_DASH && phase == G_ONE_DAY) begin
                            phase = G_AFTER_DASH;
                        end else if (kind == TOK_TIME) begin
                            for (int i = 0; i < n_days; i++)
                                expect_result(day_entry(days[i], sv, ev, i == n_days - 1));
                            phase  = G_FIRST_DAY;
                            n_days = 0;
                        end else begin
                            push_error();
                        end
                    end
                    G_AFTER_DASH: begin
                        if (kind == TOK_DAY) begin
                            days[1] = code;
                            n_days  = 2;
                            phase   = G_NEED_TIME;
                        end else begin
                            push_error();
                        end
                    end
                    G_NEED_TIME: begin
                        if (kind == TOK_TIME) begin
                            // inclusive code range, nothing when start is above end
                            for (int c = int'(days[0]); c <= int'(days[1]); c++)
                                expect_result(day_entry(3'(c), sv, ev, c == int'(days[1])));
                            phase  = G_FIRST_DAY;
                            n_days = 0;
                        end else begin
                            push_error();
                        end
                    end
                    default: push_error();
                endcase
            end
        end

        if (it.list_end) begin
            if (!dropping && phase != G_FIRST_DAY) push_error();
            phase    = G_FIRST_DAY;
            n_days   = 0;
            dropping = 1'b0;
        end
    endtask

    task automatic check_result(input dstp_pkg::out_t got);
        dstp_pkg::out_t want;
        if (expected_days.size() == 0) begin
            $error("unexpected result transfer %p", got);
            fail_count++;
            return;
        end
        want = expected_days.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
        end
        if (got.day_code !== want.day_code) begin
            $error("day_code: expected %0d, actual %0d", want.day_code, got.day_code);
            fail_count++;
        end
        if (got.start_value !== want.start_value) begin
            $error("start_value: expected %0d, actual %0d",
                   want.start_value, got.start_value);
            fail_count++;
        end
        if (got.end_value !== want.end_value) begin
            $error("end_value: expected %0d, actual %0d", want.end_value, got.end_value);
            fail_count++;
        end
        if (got.last_of_group !== want.last_of_group) begin
            $error("last_of_group: expected %0d, actual %0d",
                   want.last_of_group, got.last_of_group);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            start_token();
            phase      = G_FIRST_DAY;
            n_days     = 0;
            dropping   = 1'b0;
            fail_count = 0;
            expected_days.delete();
        end else begin
            if (s_valid && s_ready) take_char(s_data);
            if (m_valid && m_ready) check_result(m_data);
        end
        pending_results = expected_days.size();
    end

endmodule

// ===== dv/day_schedule_token_parser_tb.sv =====
// Testbench top for the schedule token parser: clock, reset, stimulus and verdict.
module day_schedule_token_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_MAX = 8;

    typedef logic [7:0] text_t[$];

    // Ways a list is broken on purpose in the random part.
    typedef enum int {
        FLAW_LEAD,          // group opens with a dash or a time range
        FLAW_JUNK,          // garbage or lowercase token after a day
        FLAW_LONG_LIST,     // one day more than the list can hold
        FLAW_LATE_DASH,     // dash after the second or third day of a list
        FLAW_DASH_NONDAY,   // dash followed by something other than a day
        FLAW_RANGE_NO_TIME, // dash range not closed by a time range
        FLAW_CUT_SHORT,     // list ends inside a group
        FLAW_BAD_TIME       // time range with a wrong char or length
    } flaw_t;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    dstp_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    dstp_pkg::out_t m_data;

    int fail_count;
    int pending_results;

    bit calm  = 1'b0;   // while set, neither side idles
    int chars_sent = 0;

    day_schedule_token_parser #(
        .LIST_MAX(LIST_MAX)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Predicts every result from the accepted chars and compares in order.
    day_schedule_result_checker #(
        .LIST_MAX(LIST_MAX)
    ) results_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Result side backpressure: about 15% stall cycles unless in a calm stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 15);
        end
    end

    // One char per transfer. Valid is dropped only for a random gap, so back-to-back
    // chars keep valid high across the accepting edge.
    task automatic send_char(input logic [7:0] c, input logic te, input logic le);
        while (!calm && $urandom_range(0, 99) < 15) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {c, te, le};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
    endtask

    // list_end on inner chars must be ignored, so it is sprinkled there at random.
    task automatic send_token(input text_t text, input logic le);
        for (int i = 0; i < text.size(); i++) begin
            if (i == text.size() - 1) send_char(text[i], 1'b1, le);
            else send_char(text[i], 1'b0, $urandom_range(0, 9) == 0);
        end
    endtask

    function automatic text_t day_text(input int code);
        text_t t;
        t = {t, dstp_pkg::DAY_NAMES[code][23:16]};
        t = {t, dstp_pkg::DAY_NAMES[code][15:8]};
        t = {t, dstp_pkg::DAY_NAMES[code][7:0]};
        return t;
    endfunction

    function automatic text_t dash_text();
        text_t t;
        t = {t, dstp_pkg::CH_DASH};
        return t;
    endfunction

    function automatic text_t time_text(input int unsigned sv, input int unsigned ev);
        text_t t;
        for (int d = 1000; d >= 1; d /= 10)
            t = {t, 8'(dstp_pkg::CH_ZERO + 8'((sv / d) % 10))};
        t = {t, dstp_pkg::CH_DASH};
        for (int d = 1000; d >= 1; d /= 10)
            t = {t, 8'(dstp_pkg::CH_ZERO + 8'((ev / d) % 10))};
        return t;
    endfunction

    // Arbitrary bytes; lengths past 15 push the char counter into saturation.
    function automatic text_t junk_text();
        text_t t;
        int    len;
        len = $urandom_range(1, 18);
        for (int i = 0; i < len; i++) t = {t, 8'($urandom_range(0, 255))};
        return t;
    endfunction

    // Times lean toward the 0000 and 9999 corners.
    function automatic int unsigned pick_time();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 9999;
            default: return $urandom_range(0, 9999);
        endcase
    endfunction

    function automatic text_t rand_time_text();
        return time_text(pick_time(), pick_time());
    endfunction

    // Well formed group: dash range or plain day list, closed by its time range.
    task automatic send_group(input logic closes_list);
        int lo;
        int hi;
        int n;
        if ($urandom_range(0, 99) < 40) begin
            lo = $urandom_range(0, 6);
            // mostly ascending, sometimes an empty range
            hi = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : $urandom_range(lo, 6);
            send_token(day_text(lo), 1'b0);
            send_token(dash_text(), 1'b0);
            send_token(day_text(hi), 1'b0);
        end else begin
            n = ($urandom_range(0, 9) == 0) ? LIST_MAX : $urandom_range(1, 3);
            for (int i = 0; i < n; i++) send_token(day_text($urandom_range(0, 6)), 1'b0);
        end
        send_token(rand_time_text(), closes_list);
    endtask

    // A list with one flaw, possibly after one good group, then drained to its end.
    task automatic send_broken();
        flaw_t flaw;
        text_t t;
        int    pos;
        flaw = flaw_t'($urandom_range(0, FLAW_BAD_TIME));
        repeat ($urandom_range(0, 1)) send_group(1'b0);
        case (flaw)
            FLAW_LEAD: begin
                if ($urandom_range(0, 1)) send_token(dash_text(), 1'b0);
                else send_token(rand_time_text(), 1'b0);
            end
            FLAW_JUNK: begin
                send_token(day_text($urandom_range(0, 6)), 1'b0);
                if ($urandom_range(0, 1)) begin
                    send_token(junk_text(), 1'b0);
                end else begin
                    // names match case-sensitively
                    t = day_text($urandom_range(0, 6));
                    foreach (t[i]) t[i] = t[i] | 8'h20;
                    send_token(t, 1'b0);
                end
            end
            FLAW_LONG_LIST: begin
                repeat (LIST_MAX + 1) send_token(day_text($urandom_range(0, 6)), 1'b0);
            end
            FLAW_LATE_DASH: begin
                repeat ($urandom_range(2, 3))
                    send_token(day_text($urandom_range(0, 6)), 1'b0);
                send_token(dash_text(), 1'b0);
            end
            FLAW_DASH_NONDAY: begin
                send_token(day_text($urandom_range(0, 6)), 1'b0);
                send_token(dash_text(), 1'b0);
                if ($urandom_range(0, 1)) send_token(dash_text(), 1'b0);
                else send_token(rand_time_text(), 1'b0);
            end
            FLAW_RANGE_NO_TIME: begin
                send_token(day_text($urandom_range(0, 6)), 1'b0);
                send_token(dash_text(), 1'b0);
                send_token(day_text($urandom_range(0, 6)), 1'b0);
                if ($urandom_range(0, 1)) send_token(day_text($urandom_range(0, 6)), 1'b0);
                else send_token(dash_text(), 1'b0);
            end
            FLAW_CUT_SHORT: begin
                // list_end lands on a day: error raised at the list end itself
                repeat ($urandom_range(0, 2)) send_token(day_text($urandom_range(0, 6)), 1'b0);
                send_token(day_text($urandom_range(0, 6)), 1'b1);
                return;
            end
            FLAW_BAD_TIME: begin
                send_token(day_text($urandom_range(0, 6)), 1'b0);
                t = rand_time_text();
                case ($urandom_range(0, 2))
                    0: begin
                        pos = $urandom_range(0, 8);
                        t[pos] = (pos == 4) ? dstp_pkg::CH_ZERO :
                                              8'($urandom_range(8'h3A, 8'hFF));
                    end
                    1: void'(t.pop_back());
                    default: t = {t, dstp_pkg::CH_NINE};
                endcase
                send_token(t, 1'b0);
            end
            default: ;
        endcase
        // everything up to the list end is dropped by the parser
        repeat ($urandom_range(0, 2)) send_token(junk_text(), 1'b0);
        if ($urandom_range(0, 1)) send_token(day_text($urandom_range(0, 6)), 1'b1);
        else send_token(rand_time_text(), 1'b1);
    endtask

    initial begin
        int lists;
        lists = 0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed ---
        // full week range with the value corners: seven day results
        send_token(day_text(0), 1'b0);
        send_token(dash_text(), 1'b0);
        send_token(day_text(6), 1'b0);
        send_token(time_text(0, 9999), 1'b1);
        // single high-bit char as a whole list: invalid token
        send_char(8'hFF, 1'b1, 1'b1);
        // orphan dash at group start
        send_token(dash_text(), 1'b1);
        // list ending right after a day
        send_token(day_text(5), 1'b1);
        // lowercase name is not a day
        send_token('{8'h6D, 8'h6F, 8'h6E}, 1'b1);

        // --- random lists: mostly well formed, a quarter broken ---
        while (chars_sent < 150) begin
            calm = (lists >= 4 && lists < 10);
            if ($urandom_range(0, 99) < 25) begin
                send_broken();
            end else begin
                repeat ($urandom_range(0, 2)) send_group(1'b0);
                send_group(1'b1);
            end
            lists++;
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        // drain, then a short quiet window to catch stray results
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/dstp_pkg.sv
design/dstp_front.sv
design/dstp_cmd_fifo.sv
design/dstp_back.sv
design/day_schedule_token_parser.sv
dv/day_schedule_result_checker.sv
dv/day_schedule_token_parser_tb.sv
